// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the frame alignment top level
// depends on nothing; users supply clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock outside reset
`define AST_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition that must never hold outside reset
`define AST_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== hw/rtl/dtw_pkg.sv =====
// shared types and constants for the dtw frame alignment block
// depends on nothing
`default_nettype none
package dtw_pkg;
  localparam int SAMPLE_BITS = 16;
  localparam int COST_BITS   = 40;
  localparam int DIST_BITS   = 24;
  localparam int CNT_BITS    = 16;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 2;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_TEST  = 2'd1;
  localparam logic [1:0] FUNC_BEGIN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT   = 2'd1;

  typedef struct packed {
    logic [1:0]                    func;
    logic [7:0]                    template_frame;
    logic [6:0]                    feature_index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last_frame;
  } in_t;

  typedef struct packed {
    logic [COST_BITS-1:0] score;
    logic [CNT_BITS-1:0]  test_frame_number;
    logic                 is_final;
    logic                 saturated;
  } out_t;
endpackage
`default_nettype wire

// ===== hw/rtl/dtw_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// depends on nothing
`default_nettype none
module dtw_ram #(
  parameter int W = 16,
  parameter int D = 256,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== hw/rtl/dtw_l1_frame_alignment.sv =====
// top level of the dtw frame alignment block: sequencer and column pipeline
// depends on dtw_pkg, dtw_ram and assert_macros.svh
`default_nettype none
// Usage
// A request is taken when start is high and busy is low. func selects:
//   load: writes one template element, done in the accept cycle, busy stays low
//   begin: clears distances, frame counter and saturation flag
//   test: walks all template frames in use, one frame per cycle, through a
//         three stage pipe (memory read, distance add, cost update)
// A test request keeps busy high until its walk has drained from the pipe, so
// the block takes no new request before it is through with the current one.
// When the feature is the last of its frame the walk also updates the cost
// column and a result appears on out_data with out_valid high for one cycle
// right after it.
// Configuration writes on cfg_we are registered and clamped to range; the feature count uses only cfg_wdata[7:0].
// Results cannot be held off; the output register frees the pipe, so the next
// request may be taken in the cycle the result is shown.
// Reset clears the control state, sets both lengths to one and needs no
// clearing pass; distance entries carry valid bits that reset clears.
module dtw_l1_frame_alignment #(
  parameter int MAX_TEMPLATE_FRAMES = 256,
  parameter int MAX_FEATURES        = 128
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire dtw_pkg::in_t                        in_data,
  output logic                                     out_valid,
  output dtw_pkg::out_t                            out_data,
  input  wire logic                                cfg_we,
  input  wire logic [dtw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dtw_pkg::CFG_W-1:0]           cfg_wdata
);
  import dtw_pkg::*;
  `include "assert_macros.svh"

  localparam int NW    = (MAX_TEMPLATE_FRAMES > 1) ? $clog2(MAX_TEMPLATE_FRAMES) : 1;
  localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int LEN_W = $clog2(MAX_TEMPLATE_FRAMES + 1);
  localparam int FC_W  = $clog2(MAX_FEATURES + 1);
  localparam int TDEP  = MAX_TEMPLATE_FRAMES * MAX_FEATURES;
  localparam int TA_W  = (TDEP > 1) ? $clog2(TDEP) : 1;

  // configuration
  logic [LEN_W-1:0] len_r;
  logic [FC_W-1:0]  fc_r;

  // sequencer
  logic                   run_r, col_r, last_r;
  logic [NW-1:0]          n_r;
  logic [FW-1:0]          feat_r;
  logic signed [SAMPLE_BITS-1:0] val_r;
  // stage 1
  logic          s1_v_r, s1_end_r, dv_q_r;
  logic [NW-1:0] s1_n_r;
  // stage 2
  logic                 s2_v_r, s2_end_r;
  logic [NW-1:0]        s2_n_r;
  logic [DIST_BITS-1:0] s2_d_r;
  logic [COST_BITS-1:0] s2_old_r;
  // column state
  logic [COST_BITS-1:0] left_r, diag_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 sat_r;
  logic [MAX_TEMPLATE_FRAMES-1:0] dv_r;
  logic                 out_valid_r;
  out_t                 out_r;

  logic accept;
  logic [NW-1:0] len_m1;
  logic [31:0]   feat_in;
  logic          feat_ok, load_ok;

  // memory ports
  logic                   t_we;
  logic [TA_W-1:0]        t_waddr, t_raddr;
  logic [SAMPLE_BITS-1:0] t_rdata;
  logic [DIST_BITS-1:0]   d_rdata, d_new;
  logic [COST_BITS-1:0]   c_rdata, c_new;

  assign accept  = start && !busy;
  assign busy    = run_r || s1_v_r || s2_v_r;
  assign len_m1  = NW'(len_r - LEN_W'(1));
  assign feat_in = 32'(in_data.feature_index);
  assign feat_ok = feat_in < 32'(fc_r);
  assign load_ok = (32'(in_data.template_frame) < MAX_TEMPLATE_FRAMES)
                && (feat_in < MAX_FEATURES);

  // template store: load on accept, read during a walk
  assign t_we    = accept && (in_data.func == FUNC_LOAD) && load_ok;
  assign t_waddr = TA_W'(int'(in_data.template_frame) * MAX_FEATURES + int'(feat_in));
  assign t_raddr = TA_W'(int'(n_r) * MAX_FEATURES + int'(feat_r));

  dtw_ram #(.W(SAMPLE_BITS), .D(TDEP)) u_tmpl (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(in_data.value),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  dtw_ram #(.W(DIST_BITS), .D(MAX_TEMPLATE_FRAMES)) u_dist (
    .clk, .we(s1_v_r), .waddr(s1_n_r), .wdata(d_new),
    .raddr(n_r), .rdata(d_rdata)
  );

  dtw_ram #(.W(COST_BITS), .D(MAX_TEMPLATE_FRAMES)) u_cost (
    .clk, .we(s2_v_r), .waddr(s2_n_r), .wdata(c_new),
    .raddr(n_r), .rdata(c_rdata)
  );

  // stage 1: absolute difference and saturating distance add
  logic signed [SAMPLE_BITS:0] diff;
  logic [SAMPLE_BITS:0]        adiff;
  logic [DIST_BITS:0]          dsum;
  logic [DIST_BITS-1:0]        dold;
  always_comb begin
    diff  = $signed({t_rdata[SAMPLE_BITS-1], t_rdata}) - $signed({val_r[SAMPLE_BITS-1], val_r});
    adiff = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : (SAMPLE_BITS+1)'(diff);
    dold  = dv_q_r ? d_rdata : '0;
    dsum  = (DIST_BITS+1)'(dold) + (DIST_BITS+1)'(adiff);
    d_new = dsum[DIST_BITS] ? '1 : dsum[DIST_BITS-1:0];
  end

  // stage 2: minimum over up to three neighbours and saturating cost add
  logic [COST_BITS-1:0] best, m1;
  logic [COST_BITS:0]   csum;
  logic                 csat;
  always_comb begin
    m1 = (left_r < s2_old_r) ? left_r : s2_old_r;
    if (cnt_r == '0) begin
      best = (s2_n_r == '0) ? '0 : left_r;
    end else if (s2_n_r == '0) begin
      best = s2_old_r;
    end else begin
      best = (diag_r < m1) ? diag_r : m1;
    end
    csum  = (COST_BITS+1)'(s2_d_r) + (COST_BITS+1)'(best);
    csat  = csum[COST_BITS];
    c_new = csat ? '1 : csum[COST_BITS-1:0];
  end

  // control and data registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_W'(1);
      fc_r        <= FC_W'(1);
      run_r       <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      cnt_r       <= '0;
      sat_r       <= 1'b0;
      dv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_v_r && s2_end_r;
      // configuration with clamping
      if (cfg_we && cfg_index == CFG_TEMPLATE_LENGTH) begin
        if (cfg_wdata == '0) len_r <= LEN_W'(1);
        else if (32'(cfg_wdata) > MAX_TEMPLATE_FRAMES) len_r <= LEN_W'(MAX_TEMPLATE_FRAMES);
        else len_r <= LEN_W'(cfg_wdata);
      end
      if (cfg_we && cfg_index == CFG_FEATURE_COUNT) begin
        if (cfg_wdata[7:0] == '0) fc_r <= FC_W'(1);
        else if (32'(cfg_wdata[7:0]) > MAX_FEATURES) fc_r <= FC_W'(MAX_FEATURES);
        else fc_r <= FC_W'(cfg_wdata[7:0]);
      end
      // request decode
      if (accept && in_data.func == FUNC_BEGIN) begin
        dv_r  <= '0;
        cnt_r <= '0;
        sat_r <= 1'b0;
      end
      if (accept && in_data.func == FUNC_TEST && feat_ok) begin
        run_r  <= 1'b1;
        n_r    <= '0;
        feat_r <= FW'(in_data.feature_index);
        val_r  <= in_data.value;
        last_r <= in_data.last_frame;
        col_r  <= feat_in == 32'(fc_r) - 32'd1;
      end
      // issue reads
      s1_v_r <= run_r;
      if (run_r) begin
        s1_n_r   <= n_r;
        s1_end_r <= n_r == len_m1;
        dv_q_r   <= dv_r[n_r];
        n_r      <= n_r + NW'(1);
        if (n_r == len_m1) run_r <= 1'b0;
      end
      // distance write back
      s2_v_r <= s1_v_r && col_r;
      if (s1_v_r) begin
        dv_r[s1_n_r] <= 1'b1;
        s2_n_r   <= s1_n_r;
        s2_end_r <= s1_end_r;
        s2_d_r   <= d_new;
        s2_old_r <= c_rdata;
      end
      // cost update and result
      if (s2_v_r) begin
        left_r <= c_new;
        diag_r <= s2_old_r;
        if (csat && !(s2_end_r && last_r)) sat_r <= 1'b1;
        if (s2_end_r) begin
          out_r.score             <= c_new;
          out_r.test_frame_number <= cnt_r;
          out_r.is_final          <= last_r;
          out_r.saturated         <= sat_r || csat;
          dv_r                    <= '0;
          if (last_r) begin
            cnt_r <= '0;
            sat_r <= 1'b0;
          end else if (cnt_r != '1) begin
            cnt_r <= cnt_r + CNT_BITS'(1);
          end
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `AST_NEVER(a_no_back_to_back, out_valid_r && $past(out_valid_r))
  `AST_CLK(a_s2_follows_s1, s2_v_r |-> $past(s1_v_r))
  `AST_CLK(a_idle_after_result, out_valid_r |-> !busy)
  `AST_NEVER(a_no_load_while_busy, t_we && (s1_v_r || s2_v_r))
endmodule
`default_nettype wire
